// File: hw/rtl/upc_pkg.sv
// ----------------------------------------------------------------------------
// URL percent codec package
// Shared constants, types and character-class helpers for the codec.
// ----------------------------------------------------------------------------
package upc_pkg;

    // Most results one input byte can produce
    localparam int MAX_RESULTS = 3;

    // Escape introducer
    localparam logic [7:0] CHAR_PCT = 8'h25;

    // Decoder hold state
    localparam logic [1:0] PEND_IDLE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    // Result beats produced for one input byte
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [MAX_RESULTS-1:0]      lasts;
        logic                        bad;
        logic [1:0]                  count;
    } res_t;

    // Decoder hold state handed back to the registers
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] digit;
    } pend_t;

    // Byte that passes through the encoder unchanged
    function automatic logic is_plain(input logic [7:0] b);
        logic hit;
        hit = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) ||
              (b >= 8'h30 && b <= 8'h39);
        hit = hit || b == 8'h7e || b == 8'h21 || b == 8'h2a || b == 8'h28 ||
              b == 8'h29 || b == 8'h5f || b == 8'h2d || b == 8'h27 ||
              b == 8'h2e || b == 8'h2b || b == 8'h3a;
        return hit;
    endfunction

    // Uppercase hex character for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10)
            c = 8'h30 + {4'd0, n};
        else
            c = 8'h37 + {4'd0, n};
        return c;
    endfunction

    // Hex digit value, either case; bit 4 set when the digit is valid
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [7:0] t;
        logic [4:0] v;
        v = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            t = b - 8'h30;
            v = {1'b1, t[3:0]};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            t = b - 8'h57;
            v = {1'b1, t[3:0]};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            t = b - 8'h37;
            v = {1'b1, t[3:0]};
        end
        return v;
    endfunction

endpackage

// File: hw/rtl/upc_xlate.sv
// ----------------------------------------------------------------------------
// URL percent codec translator
// Maps one input byte and the decoder hold state to up to three result beats.
// ----------------------------------------------------------------------------
module upc_xlate (
    input  logic            decode_mode,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    input  upc_pkg::pend_t  pend,
    output upc_pkg::res_t   res,
    output upc_pkg::pend_t  pend_next
);

    logic [4:0] h1;
    logic [4:0] h2;

    assign h1 = upc_pkg::hex_value(pend.digit);
    assign h2 = upc_pkg::hex_value(in_byte);

    always_comb
    begin
        res            = '0;
        pend_next      = '0;
        if (!decode_mode) begin
            // Encode: pass plain bytes, escape the rest
            if (upc_pkg::is_plain(in_byte)) begin
                res.bytes[0] = in_byte;
                res.lasts[0] = in_last;
                res.count    = 2'd1;
            end else begin
                res.bytes[0] = upc_pkg::CHAR_PCT;
                res.bytes[1] = upc_pkg::hex_char(in_byte[7:4]);
                res.bytes[2] = upc_pkg::hex_char(in_byte[3:0]);
                res.lasts[2] = in_last;
                res.count    = 2'd3;
            end
        end else begin
            case (pend.count)
                upc_pkg::PEND_PCT:
                begin
                    if (in_last) begin
                        // Short escape at end: flush '%' and this byte
                        res.bytes[0] = upc_pkg::CHAR_PCT;
                        res.bytes[1] = in_byte;
                        res.lasts[1] = 1'b1;
                        res.count    = 2'd2;
                    end else begin
                        pend_next.count = upc_pkg::PEND_DIGIT;
                        pend_next.digit = in_byte;
                    end
                end
                upc_pkg::PEND_DIGIT:
                begin
                    // Complete the escape; repair bad digits
                    if (!h1[4]) begin
                        res.bytes[0] = 8'h00;
                        res.bad      = 1'b1;
                    end else if (!h2[4]) begin
                        res.bytes[0] = {4'd0, h1[3:0]};
                    end else begin
                        res.bytes[0] = {h1[3:0], h2[3:0]};
                    end
                    res.lasts[0] = in_last;
                    res.count    = 2'd1;
                end
                default:
                begin
                    if (in_byte == upc_pkg::CHAR_PCT && !in_last) begin
                        pend_next.count = upc_pkg::PEND_PCT;
                    end else begin
                        res.bytes[0] = in_byte;
                        res.lasts[0] = in_last;
                        res.count    = 2'd1;
                    end
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/url_percent_codec.sv
// Latency: first result beat is valid the cycle after the input beat is accepted.
// Throughput: one input per cycle while out_ready holds and each gives one beat;
// an escaped byte in encode mode gives three beats, and the next input waits
// while the one-byte output drains the three-slot result register.
// Reset: rst_n (async, low) clears the mode to encode, the decoder hold state
// and the result register; no clearing pass is needed.
// ----------------------------------------------------------------------------
// URL percent codec
// Percent-encodes or percent-decodes a byte stream, selected by decode_mode.
// ----------------------------------------------------------------------------
module url_percent_codec (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       decode_mode_wr_en,
    input  logic       decode_mode_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       bad_escape
);

    logic                          mode_reg;
    upc_pkg::pend_t                pend_reg;
    upc_pkg::pend_t                pend_next;
    upc_pkg::res_t                 res;
    logic [upc_pkg::MAX_RESULTS-1:0][7:0] slot_byte_reg;
    logic [upc_pkg::MAX_RESULTS-1:0]      slot_last_reg;
    logic                          slot_bad_reg;
    logic [1:0]                    cnt_reg;
    logic                          take;
    logic                          accept;

    upc_xlate u_xlate (
        .decode_mode (mode_reg),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .pend        (pend_reg),
        .res         (res),
        .pend_next   (pend_next)
    );

    // Handshake: take a new beat once the last pending result leaves
    assign out_valid  = (cnt_reg != 2'd0);
    assign take       = out_valid && out_ready;
    assign in_ready   = !out_valid || (out_ready && cnt_reg == 2'd1);
    assign accept     = in_valid && in_ready;
    assign out_byte   = slot_byte_reg[0];
    assign out_last   = slot_last_reg[0];
    assign bad_escape = slot_bad_reg;

    // Mode register and decoder hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= 1'b0;
            pend_reg <= '0;
        end else if (decode_mode_wr_en) begin
            mode_reg <= decode_mode_wr_data;
            pend_reg <= '0;
        end else if (accept) begin
            pend_reg <= pend_next;
        end
    end

    // Result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end else if (accept) begin
            cnt_reg <= res.count;
        end else if (take) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Result slots: load on accept, shift down on each delivered beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slot_byte_reg <= '0;
            slot_last_reg <= '0;
            slot_bad_reg  <= 1'b0;
        end else if (accept) begin
            slot_byte_reg <= res.bytes;
            slot_last_reg <= res.lasts;
            slot_bad_reg  <= res.bad;
        end else if (take) begin
            slot_byte_reg <= {8'h00, slot_byte_reg[upc_pkg::MAX_RESULTS-1:1]};
            slot_last_reg <= {1'b0, slot_last_reg[upc_pkg::MAX_RESULTS-1:1]};
            slot_bad_reg  <= 1'b0;
        end
    end

endmodule

// File: hw/rtl/upc_checker.sv
// ----------------------------------------------------------------------------
// URL percent codec port checker
// Watches the top-level ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
module upc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last,
    input logic       bad_escape
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    // Keep the stalled payload steady
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last) &&
        $stable(bad_escape))
        else $error("output payload changed while stalled");

    // A bad escape always yields byte zero
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_escape |-> out_byte == 8'h00)
        else $error("bad escape with nonzero byte");

    // No new input while a result beat is stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

endmodule

bind url_percent_codec upc_checker u_upc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .bad_escape (bad_escape)
);
